>>> rtl/core/cffa_pkg.sv
`timescale 1ns / 1ps
package cffa_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int MAX_FILES  = 16;
	localparam int FUNC_W     = 3;
	localparam int ID_W       = 4;
	localparam int BYTE_W     = 8;
	localparam int BLK_W      = 4;
	localparam int LEN_W      = 5;
	localparam int STAT_W     = 3;

	localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_USAGE  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXISTS      = 3'd1;
	localparam logic [STAT_W-1:0] ST_TOO_BIG     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_SPACE    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd4;
	localparam logic [STAT_W-1:0] ST_UPD_TOO_BIG = 3'd5;
	localparam logic [STAT_W-1:0] ST_UPD_NOSPACE = 3'd6;

	typedef enum logic [2:0] {
		RES_PLAIN,
		RES_USAGE,
		RES_PLACED,
		RES_INPLACE,
		RES_EMPTY_READ,
		RES_READ
	} res_sel_t;

	typedef struct packed {
		logic              accept;
		logic              clr_cnt;
		logic              step;
		logic              free_blk;
		logic              scan_step;
		logic              place_blk;
		logic              shrink_blk;
		logic              set_entry;
		logic              set_len;
		logic              clr_entry;
		logic              load;
		res_sel_t          sel;
		logic [STAT_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              last_take;
		logic              entry_valid;
		logic              len_zero;
		logic              n_gt_active;
		logic              n_le_len;
		logic              run_done;
		logic              scan_hit;
		logic              scan_fail;
		logic              place_done;
		logic              read_last;
		logic              out_free;
	} sts_t;

endpackage

>>> rtl/core/cffa_in_if.sv
`timescale 1ns / 1ps
interface cffa_in_if;
	import cffa_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   file_id;
	logic [BYTE_W-1:0] data_byte;
	logic              byte_valid;
	logic              last;
	modport source(output valid, func, file_id, data_byte, byte_valid, last, input ready);
	modport sink(input valid, func, file_id, data_byte, byte_valid, last, output ready);
endinterface

>>> rtl/core/cffa_out_if.sv
`timescale 1ns / 1ps
interface cffa_out_if;
	import cffa_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [BYTE_W-1:0] read_byte;
	logic              read_valid;
	logic [BLK_W-1:0]  start_block;
	logic [LEN_W-1:0]  file_length;
	logic [LEN_W-1:0]  used_blocks;
	logic              result_last;
	modport source(output valid, status, read_byte, read_valid, start_block, file_length,
		used_blocks, result_last, input ready);
	modport sink(input valid, status, read_byte, read_valid, start_block, file_length,
		used_blocks, result_last, output ready);
endinterface

>>> rtl/core/cffa_ctrl.sv
`timescale 1ns / 1ps
module cffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  cffa_pkg::sts_t sts,
	output cffa_pkg::cmd_t cmd
);
	import cffa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_FREE   = 8'b0000_0100,
		S_SCAN   = 8'b0000_1000,
		S_PLACE  = 8'b0001_0000,
		S_SHRINK = 8'b0010_0000,
		S_READ   = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	res_sel_t          pend_sel_q, pend_sel_d;
	logic [STAT_W-1:0] pend_code_q, pend_code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_sel_q  <= RES_PLAIN;
			pend_code_q <= ST_OK;
		end else begin
			state_q     <= state_d;
			pend_sel_q  <= pend_sel_d;
			pend_code_q <= pend_code_d;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.sel     = RES_PLAIN;
		cmd.code    = ST_OK;
		state_d     = state_q;
		pend_sel_d  = pend_sel_q;
		pend_code_d = pend_code_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = 1'b1;
				if (sts.last_take) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.clr_cnt = 1'b1;
				state_d     = S_EMIT;
				pend_sel_d  = RES_PLAIN;
				pend_code_d = ST_OK;
				if (sts.func == FUNC_USAGE) begin
					pend_sel_d = RES_USAGE;
				end else if (sts.func == FUNC_CREATE) begin
					if (sts.entry_valid) pend_code_d = ST_EXISTS;
					else if (sts.n_gt_active) pend_code_d = ST_TOO_BIG;
					else state_d = S_SCAN;
				end else if (sts.func == FUNC_READ || sts.func == FUNC_UPDATE ||
						sts.func == FUNC_DELETE) begin
					if (!sts.entry_valid) pend_code_d = ST_NOT_FOUND;
					else if (sts.func == FUNC_READ) begin
						if (sts.len_zero) pend_sel_d = RES_EMPTY_READ;
						else state_d = S_READ;
					end else if (sts.func == FUNC_UPDATE && !sts.n_gt_active && sts.n_le_len)
						state_d = S_SHRINK;
					else state_d = S_FREE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				if (sts.run_done) begin
					cmd.clr_cnt = 1'b1;
					state_d     = S_EMIT;
					pend_sel_d  = RES_PLAIN;
					if (sts.func == FUNC_DELETE) begin
						cmd.clr_entry = 1'b1;
						pend_code_d   = ST_OK;
					end else if (sts.n_gt_active) begin
						cmd.clr_entry = 1'b1;
						pend_code_d   = ST_UPD_TOO_BIG;
					end else begin
						state_d = S_SCAN;
					end
				end else begin
					cmd.free_blk = 1'b1;
				end
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					cmd.scan_step = 1'b1;
					cmd.clr_cnt   = 1'b1;
					state_d       = S_PLACE;
				end else if (sts.scan_fail) begin
					state_d    = S_EMIT;
					pend_sel_d = RES_PLAIN;
					if (sts.func == FUNC_UPDATE) begin
						cmd.clr_entry = 1'b1;
						pend_code_d   = ST_UPD_NOSPACE;
					end else begin
						pend_code_d = ST_NO_SPACE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_PLACE: begin
				if (sts.place_done) begin
					cmd.set_entry = 1'b1;
					state_d       = S_EMIT;
					pend_sel_d    = RES_PLACED;
					pend_code_d   = ST_OK;
				end else begin
					cmd.place_blk = 1'b1;
				end
			end
			S_SHRINK: begin
				if (sts.run_done) begin
					cmd.set_len = 1'b1;
					state_d     = S_EMIT;
					pend_sel_d  = RES_INPLACE;
					pend_code_d = ST_OK;
				end else begin
					cmd.shrink_blk = 1'b1;
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = RES_READ;
					cmd.step = 1'b1;
					if (sts.read_last) state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = pend_sel_q;
					cmd.code = pend_code_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

>>> rtl/core/cffa_dp.sv
`timescale 1ns / 1ps
module cffa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	cffa_in_if.sink                     in_ch,
	cffa_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [cffa_pkg::LEN_W-1:0]  cfg_wdata,
	input  cffa_pkg::cmd_t              cmd,
	output cffa_pkg::sts_t              sts
);
	import cffa_pkg::*;

	logic [NUM_BLOCKS-1:0] map_q;
	logic [MAX_FILES-1:0]  ev_q;
	logic [BYTE_W-1:0]     contents_q [NUM_BLOCKS];
	logic [BYTE_W-1:0]     intake_q   [NUM_BLOCKS];
	logic [BLK_W-1:0]      est_q      [MAX_FILES];
	logic [LEN_W-1:0]      elen_q     [MAX_FILES];
	logic [LEN_W-1:0]      icnt_q;
	logic                  iover_q;
	logic [LEN_W-1:0]      active_q;
	logic [FUNC_W-1:0]     func_q;
	logic [ID_W-1:0]       id_q;
	logic [LEN_W-1:0]      n_q;
	logic [LEN_W-1:0]      cnt_q;
	logic [LEN_W-1:0]      run_q;
	logic [BLK_W-1:0]      fit_q;
	logic                  out_valid_q;
	logic [STAT_W-1:0]     status_q;
	logic [BYTE_W-1:0]     rbyte_q;
	logic                  rvalid_q;
	logic [BLK_W-1:0]      start_q;
	logic [LEN_W-1:0]      flen_q;
	logic [LEN_W-1:0]      used_q;
	logic                  rlast_q;

	logic              take, room, add, ovf;
	logic [LEN_W-1:0]  n_take, cfg_sat;
	logic [BLK_W-1:0]  st;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  run_addr, place_addr;
	logic              scan_free;
	logic [BLK_W-1:0]  hit_start;
	logic              out_free;

	assign take      = in_ch.valid && cmd.accept;
	assign in_ch.ready = cmd.accept;
	assign room      = !icnt_q[LEN_W-1];
	assign add       = in_ch.byte_valid && room;
	assign ovf       = in_ch.byte_valid && !room;
	assign n_take    = icnt_q + {{(LEN_W-1){1'b0}}, add} + {{(LEN_W-1){1'b0}}, (iover_q | ovf)};

	assign cfg_sat = (cfg_wdata == '0) ? LEN_W'(1) :
		(cfg_wdata > LEN_W'(NUM_BLOCKS)) ? LEN_W'(NUM_BLOCKS) : cfg_wdata;

	assign st         = est_q[id_q];
	assign len        = elen_q[id_q];
	assign run_addr   = {1'b0, st} + cnt_q;
	assign place_addr = {1'b0, fit_q} + cnt_q;
	assign scan_free  = (cnt_q < active_q) && !map_q[cnt_q[BLK_W-1:0]];
	// The run ends on this block, so it began n-1 blocks earlier.
	assign hit_start  = (n_q == '0) ? '0 : BLK_W'(cnt_q + LEN_W'(1) - n_q);
	assign out_free   = !out_valid_q || out_ch.ready;

	always_comb begin
		sts.func        = func_q;
		sts.last_take   = take && in_ch.last;
		sts.entry_valid = ev_q[id_q];
		sts.len_zero    = (len == '0);
		sts.n_gt_active = (n_q > active_q);
		sts.n_le_len    = (n_q <= len);
		sts.run_done    = (cnt_q == len) || run_addr[LEN_W-1];
		sts.scan_hit    = (n_q == '0) || (scan_free && (run_q + LEN_W'(1) == n_q));
		sts.scan_fail   = (n_q != '0) && (cnt_q >= active_q);
		sts.place_done  = (cnt_q == n_q);
		sts.read_last   = (cnt_q + LEN_W'(1) == len) || (run_addr == LEN_W'(NUM_BLOCKS - 1));
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			ev_q        <= '0;
			icnt_q      <= '0;
			iover_q     <= 1'b0;
			active_q    <= LEN_W'(NUM_BLOCKS);
			cnt_q       <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) active_q <= cfg_sat;
			if (take) begin
				if (in_ch.last) begin
					icnt_q  <= '0;
					iover_q <= 1'b0;
				end else begin
					icnt_q  <= icnt_q + {{(LEN_W-1){1'b0}}, add};
					iover_q <= iover_q | ovf;
				end
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
				run_q <= '0;
			end else if (cmd.step || cmd.free_blk || cmd.place_blk || cmd.shrink_blk ||
					cmd.scan_step) begin
				cnt_q <= cnt_q + LEN_W'(1);
			end
			if (cmd.scan_step && !cmd.clr_cnt) run_q <= scan_free ? run_q + LEN_W'(1) : '0;
			if (cmd.free_blk) map_q[run_addr[BLK_W-1:0]] <= 1'b0;
			if (cmd.shrink_blk && cnt_q >= n_q) map_q[run_addr[BLK_W-1:0]] <= 1'b0;
			if (cmd.place_blk) map_q[place_addr[BLK_W-1:0]] <= 1'b1;
			if (cmd.set_entry) ev_q[id_q] <= 1'b1;
			if (cmd.clr_entry) ev_q[id_q] <= 1'b0;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && add) intake_q[icnt_q[BLK_W-1:0]] <= in_ch.data_byte;
		if (take && in_ch.last) begin
			func_q <= in_ch.func;
			id_q   <= in_ch.file_id;
			n_q    <= n_take;
		end
		if (cmd.scan_step && sts.scan_hit) fit_q <= hit_start;
		if (cmd.place_blk)
			contents_q[place_addr[BLK_W-1:0]] <= intake_q[cnt_q[BLK_W-1:0]];
		if (cmd.shrink_blk && cnt_q < n_q)
			contents_q[run_addr[BLK_W-1:0]] <= intake_q[cnt_q[BLK_W-1:0]];
		if (cmd.set_entry) begin
			est_q[id_q]  <= fit_q;
			elen_q[id_q] <= n_q;
		end
		if (cmd.set_len) elen_q[id_q] <= n_q;
		if (cmd.load) begin
			status_q <= cmd.code;
			rbyte_q  <= '0;
			rvalid_q <= 1'b0;
			start_q  <= '0;
			flen_q   <= '0;
			used_q   <= '0;
			rlast_q  <= 1'b1;
			case (cmd.sel)
				RES_USAGE:   used_q <= LEN_W'($countones(map_q));
				RES_PLACED: begin
					start_q <= fit_q;
					flen_q  <= n_q;
				end
				RES_INPLACE: begin
					start_q <= st;
					flen_q  <= n_q;
				end
				RES_EMPTY_READ: start_q <= st;
				RES_READ: begin
					rbyte_q  <= contents_q[run_addr[BLK_W-1:0]];
					rvalid_q <= 1'b1;
					start_q  <= st;
					flen_q   <= len;
					rlast_q  <= sts.read_last;
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.read_byte   = rbyte_q;
	assign out_ch.read_valid  = rvalid_q;
	assign out_ch.start_block = start_q;
	assign out_ch.file_length = flen_q;
	assign out_ch.used_blocks = used_q;
	assign out_ch.result_last = rlast_q;
endmodule

>>> rtl/core/contiguous_first_fit_file_allocator.sv
`timescale 1ns / 1ps
// Channel  Role    Payload
// in_ch    sink    func, file_id, data_byte, byte_valid, last
// out_ch   source  status, read_byte, read_valid, start_block, file_length,
//                  used_blocks, result_last
// cfg      write   cfg_we, cfg_wdata (active_blocks)
// An item without last is only stored. An item with last starts the operation, which may
// free the old run, scan the bitmap and copy blocks, one block per cycle.
// Unless stalled, a read gives one result per cycle; input is held off until the last result is loaded.
// A stalled output holds its result; reset empties the store and the file table.
module contiguous_first_fit_file_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	cffa_in_if.sink                    in_ch,
	cffa_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [cffa_pkg::LEN_W-1:0] cfg_wdata
);
	import cffa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	cffa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

>>> rtl/core/cffa_checker.sv
`timescale 1ns / 1ps
module cffa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [cffa_pkg::STAT_W-1:0] status,
	input logic                        read_valid,
	input logic [cffa_pkg::LEN_W-1:0]  file_length,
	input logic [cffa_pkg::LEN_W-1:0]  used_blocks,
	input logic                        result_last
);
	import cffa_pkg::*;

	// A stalled result keeps its fields.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(file_length))
		else $error("stalled result changed");

	// Once an operation is launched, no further input transfer is taken next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input accepted while an operation runs");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> result_last)
		else $error("non-read result not marked last");

	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> status == ST_OK && file_length != '0)
		else $error("read byte with bad status or length");

	a_usage: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used_blocks != '0 |-> status == ST_OK && !read_valid)
		else $error("usage count on a non-usage result");
endmodule

bind contiguous_first_fit_file_allocator cffa_checker u_cffa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_last     (in_ch.last),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.status      (out_ch.status),
	.read_valid  (out_ch.read_valid),
	.file_length (out_ch.file_length),
	.used_blocks (out_ch.used_blocks),
	.result_last (out_ch.result_last)
);

>>> sim/tb_contiguous_first_fit_file_allocator.sv
`timescale 1ns / 1ps
module tb_contiguous_first_fit_file_allocator;
	import cffa_pkg::*;

	localparam int IDLE_WAIT   = 80;
	localparam int LONG_HOLD   = 400;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   file_id;
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] read_byte;
		logic              read_valid;
		logic [BLK_W-1:0]  start_block;
		logic [LEN_W-1:0]  file_length;
		logic [LEN_W-1:0]  used_blocks;
		logic              result_last;
	} reply_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	cffa_in_if  in_ch();
	cffa_out_if out_ch();

	contiguous_first_fit_file_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	item_t  op_items[$];
	reply_t predicted_replies[$];
	int     mismatches = 0;
	bit     send_hold = 0;
	bit     hold_req = 0;

	// Shadow copy of the store.
	bit                blk_used[NUM_BLOCKS];
	logic [BYTE_W-1:0] blk_data[NUM_BLOCKS];
	bit                file_ok[MAX_FILES];
	int                file_start[MAX_FILES];
	int                file_len[MAX_FILES];
	logic [BYTE_W-1:0] pend_bytes[NUM_BLOCKS];
	int                pend_count = 0;
	bit                pend_over = 0;
	int                usable_blocks = NUM_BLOCKS;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void add_reply(logic [STAT_W-1:0] st, int rb, bit rv, int sb, int ln,
			int ub, bit rl);
		reply_t r;
		r.status = st;
		r.read_byte = BYTE_W'(rb);
		r.read_valid = rv;
		r.start_block = BLK_W'(sb);
		r.file_length = LEN_W'(ln);
		r.used_blocks = LEN_W'(ub);
		r.result_last = rl;
		predicted_replies.push_back(r);
	endfunction

	function automatic void release_run(int s, int n);
		for (int b = s; b < s + n && b < NUM_BLOCKS; b++) blk_used[b] = 0;
	endfunction

	function automatic int lowest_free_run(int n);
		bit fits;
		for (int s = 0; s + n <= usable_blocks; s++) begin
			fits = 1;
			for (int b = s; b < s + n; b++)
				if (blk_used[b]) fits = 0;
			if (fits) return s;
		end
		return -1;
	endfunction

	function automatic void store_file(int id, int s, int n);
		for (int b = 0; b < n && s + b < NUM_BLOCKS; b++) begin
			blk_used[s + b] = 1;
			blk_data[s + b] = pend_bytes[b];
		end
		file_ok[id] = 1;
		file_start[id] = s;
		file_len[id] = n;
	endfunction

	function automatic void apply_transfer(item_t it);
		int n, s, st, ln, cnt, id;
		id = it.file_id;
		if (it.byte_valid) begin
			if (pend_count < NUM_BLOCKS) pend_bytes[pend_count++] = it.data_byte;
			else pend_over = 1;
		end
		if (!it.last) return;
		n = pend_count + pend_over;
		pend_count = 0;
		pend_over = 0;
		if (it.func == FUNC_USAGE) begin
			cnt = 0;
			foreach (blk_used[b]) cnt += blk_used[b];
			add_reply(ST_OK, 0, 0, 0, 0, cnt, 1);
			return;
		end
		if (it.func > FUNC_USAGE) return;
		if (it.func != FUNC_CREATE && !file_ok[id]) begin
			add_reply(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
			return;
		end
		st = file_start[id];
		ln = file_len[id];
		case (it.func)
			FUNC_CREATE: begin
				if (file_ok[id]) add_reply(ST_EXISTS, 0, 0, 0, 0, 0, 1);
				else if (n > usable_blocks) add_reply(ST_TOO_BIG, 0, 0, 0, 0, 0, 1);
				else begin
					s = lowest_free_run(n);
					if (s < 0) add_reply(ST_NO_SPACE, 0, 0, 0, 0, 0, 1);
					else begin
						store_file(id, s, n);
						add_reply(ST_OK, 0, 0, s, n, 0, 1);
					end
				end
			end
			FUNC_READ: begin
				if (ln == 0) add_reply(ST_OK, 0, 0, st, 0, 0, 1);
				else
					for (int b = 0; b < ln && st + b < NUM_BLOCKS; b++)
						add_reply(ST_OK, blk_data[st + b], 1, st, ln, 0,
							(b + 1 == ln) || (st + b + 1 == NUM_BLOCKS));
			end
			FUNC_DELETE: begin
				release_run(st, ln);
				file_ok[id] = 0;
				add_reply(ST_OK, 0, 0, 0, 0, 0, 1);
			end
			default: begin
				if (n > usable_blocks) begin
					release_run(st, ln);
					file_ok[id] = 0;
					add_reply(ST_UPD_TOO_BIG, 0, 0, 0, 0, 0, 1);
				end else if (n <= ln) begin
					for (int b = 0; b < ln && st + b < NUM_BLOCKS; b++) begin
						if (b < n) blk_data[st + b] = pend_bytes[b];
						else blk_used[st + b] = 0;
					end
					file_len[id] = n;
					add_reply(ST_OK, 0, 0, st, n, 0, 1);
				end else begin
					release_run(st, ln);
					s = lowest_free_run(n);
					if (s < 0) begin
						file_ok[id] = 0;
						add_reply(ST_UPD_NOSPACE, 0, 0, 0, 0, 0, 1);
					end else begin
						store_file(id, s, n);
						add_reply(ST_OK, 0, 0, s, n, 0, 1);
					end
				end
			end
		endcase
	endfunction

	// Queues one operation as nbytes transfers (one empty if 0) ending in last.
	task automatic queue_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id, int nbytes);
		item_t it;
		int total;
		total = (nbytes == 0) ? 1 : nbytes;
		for (int i = 0; i < total; i++) begin
			it.func = ($urandom_range(0, 3) == 0 && i + 1 < total) ?
				FUNC_W'($urandom_range(0, 7)) : f;
			it.file_id = (i + 1 < total) ? ID_W'($urandom_range(0, 15)) : id;
			it.data_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : BYTE_W'($urandom_range(0, 255));
			if (nbytes > 2) it.data_byte = BYTE_W'($urandom_range(0, 255));
			it.byte_valid = (nbytes != 0);
			it.last = (i + 1 == total);
			op_items.push_back(it);
		end
	endtask

	task automatic queue_random_op();
		logic [FUNC_W-1:0] f;
		int pick, n;
		pick = $urandom_range(0, 99);
		if (pick < 30) f = FUNC_CREATE;
		else if (pick < 50) f = FUNC_READ;
		else if (pick < 68) f = FUNC_UPDATE;
		else if (pick < 82) f = FUNC_DELETE;
		else if (pick < 94) f = FUNC_USAGE;
		else f = FUNC_W'($urandom_range(5, 7));
		n = $urandom_range(0, 5);
		if ($urandom_range(0, 14) == 0) n = $urandom_range(14, 18);
		if ((f == FUNC_READ || f == FUNC_DELETE || f == FUNC_USAGE) && $urandom_range(0, 3) != 0)
			n = 0;
		queue_op(f, ($urandom_range(0, 5) == 0) ? ID_W'($urandom_range(0, 15)) :
			ID_W'($urandom_range(0, 5)), n);
	endtask

	task automatic wait_idle();
		while (op_items.size() > 0 || in_ch.valid || predicted_replies.size() > 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_active(logic [LEN_W-1:0] v);
		int sat;
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sat = v;
		if (sat < 1) sat = 1;
		if (sat > NUM_BLOCKS) sat = NUM_BLOCKS;
		usable_blocks = sat;
	endtask

	// Sender: bursts of transfers separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_ch.valid <= 0;
			end else if (op_items.size() > 0 && !send_hold) begin
				item_t it;
				it = op_items.pop_front();
				in_ch.func <= it.func;
				in_ch.file_id <= it.file_id;
				in_ch.data_byte <= it.data_byte;
				in_ch.byte_valid <= it.byte_valid;
				in_ch.last <= it.last;
				in_ch.valid <= 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && in_ch.valid && in_ch.ready)
			apply_transfer({in_ch.func, in_ch.file_id, in_ch.data_byte, in_ch.byte_valid,
				in_ch.last});

	// Receiver: stall pattern with calm stretches, plus one long hold on request.
	int hold_left = 0;
	bit hold_done = 0;
	int mode_left = 0;
	int stall_pct = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			hold_left <= 0;
			hold_done <= 0;
			mode_left <= 0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_left <= LONG_HOLD;
			out_ch.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(10, 60);
				stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (predicted_replies.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				reply_t r;
				r = predicted_replies.pop_front();
				check_field("status", r.status, out_ch.status);
				check_field("read_byte", r.read_byte, out_ch.read_byte);
				check_field("read_valid", r.read_valid, out_ch.read_valid);
				check_field("start_block", r.start_block, out_ch.start_block);
				check_field("file_length", r.file_length, out_ch.file_length);
				check_field("used_blocks", r.used_blocks, out_ch.used_blocks);
				check_field("result_last", r.result_last, out_ch.result_last);
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STUCK_LIMIT) begin
			$display("[contiguous_first_fit_file_allocator] ERROR");
			$finish;
		end
	end

	initial begin
		logic [LEN_W-1:0] settings[6];
		settings = '{5'd8, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_ch.valid = 0;
		in_ch.func = 0;
		in_ch.file_id = 0;
		in_ch.data_byte = 0;
		in_ch.byte_valid = 0;
		in_ch.last = 0;
		out_ch.ready = 0;
		for (int i = 0; i < NUM_BLOCKS; i++) blk_used[i] = 0;
		for (int i = 0; i < MAX_FILES; i++) file_ok[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		write_active(5'd16);

		// Directed part.
		queue_op(FUNC_CREATE, 4'd0, 3);
		queue_op(FUNC_READ, 4'd0, 0);
		queue_op(FUNC_CREATE, 4'd0, 2);
		queue_op(FUNC_UPDATE, 4'd0, 2);
		queue_op(FUNC_UPDATE, 4'd0, 5);
		queue_op(FUNC_READ, 4'd0, 0);
		queue_op(FUNC_CREATE, 4'd15, 0);
		queue_op(FUNC_READ, 4'd15, 0);
		queue_op(FUNC_CREATE, 4'd7, 10);
		queue_op(FUNC_CREATE, 4'd8, 4);
		queue_op(FUNC_USAGE, 4'd3, 0);
		queue_op(FUNC_READ, 4'd7, 2);
		queue_op(FUNC_UPDATE, 4'd15, 17);
		queue_op(FUNC_UPDATE, 4'd7, 12);
		queue_op(FUNC_CREATE, 4'd9, 18);
		queue_op(FUNC_DELETE, 4'd0, 0);
		queue_op(FUNC_READ, 4'd0, 0);
		queue_op(FUNC_DELETE, 4'd9, 0);
		queue_op(3'd5, 4'd1, 2);
		queue_op(3'd7, 4'd1, 0);
		queue_op(FUNC_CREATE, 4'd1, 16);
		queue_op(FUNC_USAGE, 4'd0, 0);
		wait_idle();

		// Fill the block with reads and random operations while the receiver holds off for a long stretch.
		hold_req = 1;
		for (int i = 0; i < 4; i++) queue_op(FUNC_READ, 4'd1, 0);
		for (int i = 0; i < 15; i++) queue_random_op();
		wait_idle();

		foreach (settings[k]) begin
			write_active(settings[k]);
			for (int i = 0; i < 5; i++) queue_random_op();
			while (op_items.size() > 0) @(posedge clk);
			// Hold the sender back until every result is back, then continue.
			send_hold = 1;
			for (int i = 0; i < 3; i++) queue_random_op();
			while (in_ch.valid || predicted_replies.size() > 0) @(posedge clk);
			send_hold = 0;
			wait_idle();
		end

		if (mismatches == 0)
			$display("[contiguous_first_fit_file_allocator] OK");
		else
			$display("[contiguous_first_fit_file_allocator] ERROR");
		$finish;
	end

endmodule
